// ===== sv/ssd_pkg.sv =====
// Shared types, constants and segment table for the stopwatch display driver.
// No dependencies; compiled first.
package ssd_pkg;

	localparam int DIGITS_DEFAULT = 5;
	localparam int COUNT_DIGITS   = 5;
	localparam int COUNT_W        = 17;
	localparam int COUNT_WRAP     = 100000;
	localparam int START_BIT      = 5;
	localparam int STOP_BIT       = 6;

	localparam logic [7:0] SEL_FIRST = 8'h80;
	localparam logic [7:0] SEG_BLANK = 8'h00;

	typedef logic [3:0] bcd_t;

	typedef enum logic {
		OP_TICK   = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] buttons;
	} cmd_t;

	typedef struct packed {
		logic [7:0]         digit_select;
		logic [7:0]         segments;
		logic               last_frame;
		logic               indicator;
		logic               stop_report;
		logic [COUNT_W-1:0] elapsed_ms;
	} frame_t;

	// count cell control: synchronous clear and carry in
	typedef struct packed {
		logic clear;
		logic inc;
	} cnt_ctrl_t;

	// frame cell control: parallel load or shift toward the output
	typedef struct packed {
		logic load;
		logic shift;
	} frm_ctrl_t;

	localparam logic [7:0] SEG_TABLE [10] = '{
		8'hAF, 8'hA0, 8'h6E, 8'hEA, 8'hE1, 8'hCB, 8'hCF, 8'hA2, 8'hEF, 8'hEB
	};

	function automatic logic [7:0] seg_of(input bcd_t d);
		logic [7:0] s;
		s = SEG_BLANK;
		if (d < 4'd10) begin
			s = SEG_TABLE[d];
		end
		return s;
	endfunction

endpackage

// ===== sv/ssd_if.sv =====
// Valid/ready channels for the stopwatch display driver.
// Depends on ssd_pkg for the payload types.
interface ssd_cmd_if;
	logic        valid;
	logic        ready;
	ssd_pkg::cmd_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface ssd_frame_if;
	logic          valid;
	logic          ready;
	ssd_pkg::frame_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== sv/ssd_count_cell.sv =====
// One decimal digit of the millisecond count; cells chain through carry.
// Depends on ssd_pkg.
module ssd_count_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  ssd_pkg::cnt_ctrl_t ctrl,
	output ssd_pkg::bcd_t      digit,
	output logic               carry
);
	import ssd_pkg::*;

	bcd_t digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.inc) begin
			digit_q <= (digit_q == 4'd9) ? 4'd0 : digit_q + 4'd1;
		end
	end

	assign digit = digit_q;
	assign carry = ctrl.inc && (digit_q == 4'd9);

endmodule

// ===== sv/ssd_frame_cell.sv =====
// One slot of the display frame line: loads a segment byte, then shifts it
// toward the output one frame at a time. Depends on ssd_pkg.
module ssd_frame_cell (
	input  logic               clk,
	input  ssd_pkg::frm_ctrl_t ctrl,
	input  logic [7:0]         load_seg,
	input  logic [7:0]         next_seg,
	output logic [7:0]         seg
);
	import ssd_pkg::*;

	logic [7:0] seg_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			seg_q <= load_seg;
		end else if (ctrl.shift) begin
			seg_q <= next_seg;
		end
	end

	assign seg = seg_q;

endmodule

// ===== sv/stopwatch_seven_segment_driver_unit.sv =====
// Stopwatch with seven-segment frame output: top level.
// Depends on ssd_pkg, ssd_if, ssd_count_cell and ssd_frame_cell.
//
// Usage:
//   cmd carries one request per handshake: operation 0 is a millisecond tick,
//   operation 1 a sample of the active-low buttons (bit 5 start, bit 6 stop).
//   A tick updates the count and gives no frame. A sample gives DIGITS frames
//   on the frame channel, ones digit first, the last one flagged last_frame.
//   The count is kept as a chain of decimal digit cells plus a binary copy
//   for elapsed_ms; both wrap from 99999 to 0.
//   Latency: the first frame of a sample is valid the cycle after the request
//   is taken. Throughput: one frame per cycle from the frame shift line while
//   frame.ready stays high.
//   cmd.ready is high while no frames are pending and in the cycle that the
//   last frame is taken, so back-to-back samples stream without gaps.
//   When the receiver stalls, the current frame holds and cmd.ready stays low
//   until the last frame of the refresh is taken.
//   Reset: count zero, stopped, buttons seen released, indicator high, no
//   frames pending.
module stopwatch_seven_segment_driver_unit #(
	parameter int DIGITS = ssd_pkg::DIGITS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	ssd_cmd_if.sink            cmd,
	ssd_frame_if.source        frame
);
	import ssd_pkg::*;

	localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGITS - 1);

	// stopwatch state
	logic [COUNT_W-1:0] millis_q;
	logic               running_q;
	logic               start_held_q;
	logic               stop_held_q;
	logic               indicator_q;

	// frame emitter state
	logic               busy_q;
	logic [IDX_W-1:0]   idx_q;
	logic               report_q;
	logic [COUNT_W-1:0] elapsed_q;

	logic cmd_acc, tick, sample, start_low, stop_low, start_edge, stop_edge;
	logic frame_acc, finishing;

	assign frame_acc = frame.valid && frame.ready;
	assign finishing = frame_acc && (idx_q == LAST_IDX);
	assign cmd.ready = !busy_q || finishing;
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign tick      = cmd_acc && (cmd.payload.operation == OP_TICK);
	assign sample    = cmd_acc && (cmd.payload.operation == OP_SAMPLE);

	assign start_low  = !cmd.payload.buttons[START_BIT];
	assign stop_low   = !cmd.payload.buttons[STOP_BIT];
	assign start_edge = start_low && !start_held_q;
	assign stop_edge  = stop_low && !stop_held_q;

	// decimal count cells
	bcd_t      digit_w [COUNT_DIGITS];
	logic      carry_w [COUNT_DIGITS];
	cnt_ctrl_t cctl    [COUNT_DIGITS];

	for (genvar i = 0; i < COUNT_DIGITS; i++) begin : g_count
		assign cctl[i].clear = sample && start_edge;
		if (i == 0) begin : g_first
			assign cctl[i].inc = tick && running_q;
		end else begin : g_rest
			assign cctl[i].inc = carry_w[i-1];
		end
		ssd_count_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctrl  (cctl[i]),
			.digit (digit_w[i]),
			.carry (carry_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			millis_q     <= '0;
			running_q    <= 1'b0;
			start_held_q <= 1'b0;
			stop_held_q  <= 1'b0;
			indicator_q  <= 1'b1;
		end else if (sample) begin
			start_held_q <= start_low;
			stop_held_q  <= stop_low;
			if (start_edge) begin
				millis_q    <= '0;
				indicator_q <= 1'b0;
			end else if (!start_low && start_held_q) begin
				indicator_q <= 1'b1;
			end
			// stop wins over start within one sample
			if (stop_edge) begin
				running_q <= 1'b0;
			end else if (start_edge) begin
				running_q <= 1'b1;
			end
		end else if (tick && running_q) begin
			millis_q <= (millis_q == COUNT_W'(COUNT_WRAP - 1)) ? '0
				: millis_q + COUNT_W'(1);
		end
	end

	// frame shift line
	frm_ctrl_t  fctl;
	logic [7:0] seg_w [DIGITS];

	assign fctl.load  = sample;
	assign fctl.shift = frame_acc;

	for (genvar i = 0; i < DIGITS; i++) begin : g_frame
		logic [7:0] load_seg;
		logic [7:0] next_seg;
		if (i < COUNT_DIGITS) begin : g_cnt
			assign load_seg = start_edge ? seg_of(4'd0) : seg_of(digit_w[i]);
		end else begin : g_zero
			assign load_seg = seg_of(4'd0);
		end
		if (i == DIGITS - 1) begin : g_end
			assign next_seg = SEG_BLANK;
		end else begin : g_mid
			assign next_seg = seg_w[i+1];
		end
		ssd_frame_cell u_cell (
			.clk     (clk),
			.ctrl    (fctl),
			.load_seg(load_seg),
			.next_seg(next_seg),
			.seg     (seg_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (sample) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (finishing) begin
			busy_q <= 1'b0;
		end else if (frame_acc) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (sample) begin
			report_q  <= stop_edge;
			elapsed_q <= (stop_edge && !start_edge) ? millis_q : '0;
		end
	end

	assign frame.valid                = busy_q;
	assign frame.payload.digit_select = 8'(SEL_FIRST >> idx_q);
	assign frame.payload.segments     = seg_w[0];
	assign frame.payload.last_frame   = (idx_q == LAST_IDX);
	assign frame.payload.indicator    = indicator_q;
	assign frame.payload.stop_report  = report_q;
	assign frame.payload.elapsed_ms   = elapsed_q;

	// checks
	logic digits_zero;
	always_comb begin
		digits_zero = 1'b1;
		for (int i = 0; i < COUNT_DIGITS; i++) begin
			if (digit_w[i] != 4'd0) begin
				digits_zero = 1'b0;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		millis_q < COUNT_W'(COUNT_WRAP))
		else $error("binary count out of range");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		(millis_q == '0) == digits_zero)
		else $error("decimal cells disagree with binary count");

	a_first_frame: assert property (@(posedge clk) disable iff (!arst_n)
		sample |=> (frame.valid && idx_q == '0))
		else $error("sample did not start a refresh");

	a_frame_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_acc && idx_q != LAST_IDX) |=> frame.valid)
		else $error("refresh ended early");

	a_report_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !sample) |=> ($stable(report_q) && $stable(elapsed_q)))
		else $error("stop report changed within a refresh");

endmodule

// ===== sim/stopwatch_frame_checker.sv =====
// Frame scoreboard for the stopwatch display driver: watches both channels,
// predicts the display frames of every request and compares them in order.
// Depends on ssd_pkg for the payload types and the operation codes.
module stopwatch_frame_checker #(
	parameter int DIGITS = ssd_pkg::DIGITS_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  logic            cmd_ready,
	input  ssd_pkg::cmd_t   cmd_payload,
	input  logic            frame_valid,
	input  logic            frame_ready,
	input  ssd_pkg::frame_t frame_payload,
	output int unsigned     mismatches,
	output int unsigned     frames_due
);
	timeunit 1ns;
	timeprecision 1ps;

	import ssd_pkg::*;

	localparam int WRAP_MS      = 100000;
	localparam logic [7:0] DIGIT_SEG [10] = '{
		8'hAF, 8'hA0, 8'h6E, 8'hEA, 8'hE1, 8'hCB, 8'hCF, 8'hA2, 8'hEF, 8'hEB
	};

	logic [COUNT_W-1:0] ms_count;
	logic               running;
	logic               start_held;
	logic               stop_held;
	logic               ind_level;
	frame_t             expected_frames[$];

	function automatic void apply_request(input cmd_t req);
		logic               start_low;
		logic               stop_low;
		logic               report;
		logic [COUNT_W-1:0] elapsed;
		int unsigned        rest;
		frame_t             f;
		if (req.operation == OP_TICK) begin
			if (running) begin
				ms_count = (ms_count >= WRAP_MS - 1) ? '0 : ms_count + 1'b1;
			end
		end else begin
			start_low = !req.buttons[START_BIT];
			stop_low  = !req.buttons[STOP_BIT];
			report    = 1'b0;
			elapsed   = '0;
			// start goes first, so a joint press reports a cleared count
			if (start_low && !start_held) begin
				ind_level  = 1'b0;
				running    = 1'b1;
				ms_count   = '0;
				start_held = 1'b1;
			end else if (!start_low && start_held) begin
				ind_level  = 1'b1;
				start_held = 1'b0;
			end
			if (stop_low && !stop_held) begin
				running   = 1'b0;
				report    = 1'b1;
				elapsed   = ms_count;
				stop_held = 1'b1;
			end else if (!stop_low && stop_held) begin
				stop_held = 1'b0;
			end
			rest = ms_count;
			for (int i = 0; i < DIGITS && i < 8; i++) begin
				f.digit_select = 8'h80 >> i;
				f.segments     = DIGIT_SEG[rest % 10];
				f.last_frame   = (i == DIGITS - 1) || (i == 7);
				f.indicator    = ind_level;
				f.stop_report  = report;
				f.elapsed_ms   = elapsed;
				expected_frames.push_back(f);
				rest = rest / 10;
			end
		end
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_t want;
		if (!arst_n) begin
			ms_count   = '0;
			running    = 1'b0;
			start_held = 1'b0;
			stop_held  = 1'b0;
			ind_level  = 1'b1;
			expected_frames.delete();
			mismatches = 0;
		end else begin
			if (frame_valid && frame_ready) begin
				if (expected_frames.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected frame, expected none, actual %h",
						$time, frame_payload);
				end else begin
					want = expected_frames.pop_front();
					check_field("digit_select", want.digit_select, frame_payload.digit_select);
					check_field("segments", want.segments, frame_payload.segments);
					check_field("last_frame", want.last_frame, frame_payload.last_frame);
					check_field("indicator", want.indicator, frame_payload.indicator);
					check_field("stop_report", want.stop_report, frame_payload.stop_report);
					check_field("elapsed_ms", want.elapsed_ms, frame_payload.elapsed_ms);
				end
			end
			if (cmd_valid && cmd_ready) begin
				apply_request(cmd_payload);
			end
		end
		frames_due = expected_frames.size();
	end

endmodule

// ===== sim/tb_stopwatch_seven_segment_driver_unit.sv =====
// Testbench top for the stopwatch display driver: clock, reset, request and
// frame-channel stimulus, verdict. Depends on ssd_pkg, ssd_if, the RTL and
// stopwatch_frame_checker.
module tb_stopwatch_seven_segment_driver_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ssd_pkg::*;

	localparam int RUN_TICKS       = 12;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 20;
	localparam int RANDOM_ITEMS    = 280;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned idle_pct    = 0;
	int unsigned stall_pct   = 0;
	int unsigned hold_cycles = 0;
	int unsigned mismatches;
	int unsigned frames_due;
	logic        start_lvl = 1'b1;
	logic        stop_lvl  = 1'b1;

	ssd_cmd_if   cmd_ch();
	ssd_frame_if frame_ch();

	stopwatch_seven_segment_driver_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.frame  (frame_ch)
	);

	stopwatch_frame_checker u_frame_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_ch.valid),
		.cmd_ready     (cmd_ch.ready),
		.cmd_payload   (cmd_ch.payload),
		.frame_valid   (frame_ch.valid),
		.frame_ready   (frame_ch.ready),
		.frame_payload (frame_ch.payload),
		.mismatches    (mismatches),
		.frames_due    (frames_due)
	);

	always #2 clk = ~clk;

	initial begin
		#4_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// frame receiver; a pending hold-off overrides the random stalls
	initial begin
		frame_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				frame_ch.ready <= 1'b0;
			end else if (hold_cycles != 0) begin
				frame_ch.ready <= 1'b0;
				hold_cycles--;
			end else begin
				frame_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_request(input op_t op, input logic [7:0] btn);
		while ($urandom_range(99) < idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.payload <= {op, btn};
		@(posedge clk);
		while (!cmd_ch.ready) begin
			@(posedge clk);
		end
	endtask

	task automatic send_ticks(input int unsigned n);
		repeat (n) begin
			send_request(OP_TICK, 8'($urandom_range(255)));
		end
	endtask

	task automatic random_action();
		int unsigned pick;
		logic [7:0]  btn;
		pick = $urandom_range(99);
		btn  = 8'($urandom_range(255));
		if (pick < 35) begin
			send_request(OP_TICK, btn);
		end else if (pick < 38) begin
			send_ticks($urandom_range(12, 4));
		end else if (pick < 90) begin
			// tracked button levels, so presses and releases form real edges
			if (pick < 52 || pick >= 76) begin
				start_lvl = ~start_lvl;
			end
			if ((pick >= 52 && pick < 66) || pick >= 76) begin
				stop_lvl = ~stop_lvl;
			end
			btn[START_BIT] = start_lvl;
			btn[STOP_BIT]  = stop_lvl;
			send_request(OP_SAMPLE, btn);
		end else if ($urandom_range(1) == 1) begin
			start_lvl = btn[START_BIT];
			stop_lvl  = btn[STOP_BIT];
			send_request(OP_SAMPLE, btn);
		end else begin
			send_request(OP_TICK, btn);
		end
	endtask

	initial begin
		cmd_ch.valid   <= 1'b0;
		cmd_ch.payload <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle sample, tick while stopped, joint press, stop while stopped
		send_request(OP_SAMPLE, 8'hFF);
		send_request(OP_TICK, 8'h00);
		send_request(OP_SAMPLE, 8'h00);
		send_request(OP_SAMPLE, 8'hFF);
		send_request(OP_SAMPLE, 8'hBF);
		send_request(OP_SAMPLE, 8'hFF);
		// start, held start ignored, release raises the indicator
		send_request(OP_SAMPLE, 8'hDF);
		send_request(OP_SAMPLE, 8'hDF);
		send_ticks(7);
		send_request(OP_SAMPLE, 8'h5F);
		send_request(OP_SAMPLE, 8'hFF);
		// more counting, stop, released stop, stop while stopped
		send_ticks(RUN_TICKS);
		send_request(OP_SAMPLE, 8'hFF);
		send_request(OP_TICK, 8'hFF);
		send_request(OP_SAMPLE, 8'hFF);
		send_ticks(3);
		send_request(OP_SAMPLE, 8'h20);
		send_request(OP_SAMPLE, 8'hBF);
		send_request(OP_TICK, 8'hFF);
		send_request(OP_SAMPLE, 8'hFF);
		send_request(OP_SAMPLE, 8'hBF);
		send_request(OP_SAMPLE, 8'hFF);
		// joint press, then a fresh start and a stop after a longer run
		send_request(OP_SAMPLE, 8'h9F);
		send_request(OP_SAMPLE, 8'hFF);
		send_request(OP_SAMPLE, 8'hDF);
		send_ticks(2 * RUN_TICKS + 1);
		send_request(OP_SAMPLE, 8'hBF);
		send_request(OP_SAMPLE, 8'hFF);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 77;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 77;
				end
				default: begin
					idle_pct  = 25;
					stall_pct = 25;
				end
			endcase
			// long receiver hold-off while requests keep coming
			if (ph == 0 || ph == 3) begin
				hold_cycles = HOLD_OFF_CYCLES;
			end
			repeat (RANDOM_ITEMS / 4) begin
				random_action();
			end
		end
		cmd_ch.valid <= 1'b0;

		while (frames_due != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/ssd_pkg.sv
sv/ssd_if.sv
sv/ssd_count_cell.sv
sv/ssd_frame_cell.sv
sv/stopwatch_seven_segment_driver_unit.sv
sim/stopwatch_frame_checker.sv
sim/tb_stopwatch_seven_segment_driver_unit.sv
